[hw/rtl/b64d_pkg.sv]
// b64d_pkg: shared types for the base64 stream decoder
// item structs for both channels, the group record and the queue status
// no dependencies
package b64d_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       final_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       group_last;
        logic       stream_end;
    } out_item_t;

    // one closed group: bytes packed to the front, count 1..3
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n_bytes;
        logic            fin;
    } group_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[hw/rtl/b64d_front.sv]
// b64d_front: character intake, sextet lookup and group assembly
// emits one group record per closed group
// depends on b64d_pkg
module b64d_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  b64d_pkg::in_item_t       in_data,
    input  logic                     q_full,
    output logic                     q_push,
    output b64d_pkg::group_rec_t     q_rec
);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    function automatic logic [5:0] sextet_of(input logic [7:0] ch);
        logic [5:0] res;
        res = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            res = 6'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            res = 6'(ch - 8'h61 + 8'd26);
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = 6'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B)
        begin
            res = 6'd62;
        end
        else if (ch == 8'h2F)
        begin
            res = 6'd63;
        end
        return res;
    endfunction

    logic [2:0][5:0] store_reg;
    logic [2:0][5:0] store_next;
    logic [1:0]      gc_reg;
    logic [1:0]      gc_next;
    logic            prev_pad_reg;
    logic            prev_pad_next;

    logic       accept;
    logic       close;
    logic       is_pad;
    logic [5:0] val;
    logic [5:0] v0, v1, v2, v3;
    logic [7:0] b1, b2, b3;

    always_comb
    begin
        accept = push && !q_full;
        val    = sextet_of(in_data.char_in);
        is_pad = (in_data.char_in == PAD_CHAR);
        close  = in_data.final_char || (gc_reg == 2'd3);

        // slots past the fill count are always zero
        v0 = (gc_reg == 2'd0) ? val : store_reg[0];
        v1 = (gc_reg == 2'd1) ? val : store_reg[1];
        v2 = (gc_reg == 2'd2) ? val : store_reg[2];
        v3 = (gc_reg == 2'd3) ? val : 6'd0;

        b1 = {v0, v1[5:4]};
        b2 = {v1[3:0], v2[5:2]};
        b3 = {v2[1:0], v3};

        q_rec.bytes[0] = b1;
        q_rec.bytes[1] = prev_pad_reg ? b3 : b2;
        q_rec.bytes[2] = b3;
        q_rec.n_bytes  = 2'd1 + {1'b0, !prev_pad_reg} + {1'b0, !is_pad};
        q_rec.fin      = in_data.final_char;

        q_push = accept && close;

        store_next    = store_reg;
        gc_next       = gc_reg;
        prev_pad_next = prev_pad_reg;
        if (accept)
        begin
            prev_pad_next = is_pad;
            if (close)
            begin
                store_next = '0;
                gc_next    = 2'd0;
            end
            else
            begin
                store_next[gc_reg] = val;
                gc_next            = gc_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg    <= '0;
            gc_reg       <= 2'd0;
            prev_pad_reg <= 1'b0;
        end
        else
        begin
            store_reg    <= store_next;
            gc_reg       <= gc_next;
            prev_pad_reg <= prev_pad_next;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
// b64d_queue: small fifo of group records between front and back
// register array with a read pointer, write pointer and fill count
// depends on b64d_pkg
module b64d_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr,
    input  b64d_pkg::group_rec_t     wr_rec,
    input  logic                     rd,
    output b64d_pkg::group_rec_t     head,
    output b64d_pkg::queue_status_t  status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::group_rec_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    always_comb
    begin
        status.full  = (cnt_reg == CNT_W'(DEPTH));
        status.empty = (cnt_reg == '0);
        head         = mem_reg[rd_ptr_reg];
        do_wr        = wr && !status.full;
        do_rd        = rd && !status.empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not rise on write");
    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count did not fall on read");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");
`endif

endmodule

[hw/rtl/b64d_back.sv]
// b64d_back: walks the bytes of the head group record onto the result port
// byte index counter and last/end flag generation
// depends on b64d_pkg
module b64d_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  b64d_pkg::group_rec_t     head,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  logic                     pop,
    output logic                     empty,
    output b64d_pkg::out_item_t      out_data
);

    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic       last;
    logic       take;

    always_comb
    begin
        empty = q_empty;
        take  = pop && !q_empty;
        last  = (k_reg == head.n_bytes - 2'd1);

        case (k_reg)
            2'd0:    out_data.byte_out = head.bytes[0];
            2'd1:    out_data.byte_out = head.bytes[1];
            2'd2:    out_data.byte_out = head.bytes[2];
            default: out_data.byte_out = 8'd0;
        endcase
        out_data.group_last = last;
        out_data.stream_end = last && head.fin;

        q_pop  = take && last;
        k_next = k_reg;
        if (take)
        begin
            k_next = last ? 2'd0 : k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 2'd0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

`ifndef SYNTHESIS
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> head.n_bytes != 2'd0)
        else $error("group record with no bytes");
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> k_reg < head.n_bytes)
        else $error("byte index past group size");
    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> k_reg == 2'd0)
        else $error("byte index not cleared while queue empty");
`endif

endmodule

[hw/rtl/base64_stream_decoder.sv]
// base64_stream_decoder: top level of the base64 text stream decoder
// ties front, group queue and back together
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
//
// usage
//   input channel: in_data carries one character and its final flag; a
//   transfer happens on a rising edge with push high and full low
//   result channel: out_data holds the oldest decoded byte while empty is
//   low; a transfer happens on a rising edge with pop high and empty low
//   the front takes one character per cycle while full is low and, when
//   a group closes (fourth character or a final flag), writes a record
//   of 1..3 bytes into a QUEUE_DEPTH-entry queue; the back hands those
//   bytes out one per cycle while pop is high
//   latency: with the queue empty, a closing character's first byte is
//   visible the cycle after its transfer; later bytes follow one per pop
//   throughput: one character per cycle while full is low; one byte
//   per pop out, so the queue absorbs bursts of short final groups
//   receiver stall: records pile up in the queue; once it is full, full
//   rises and characters are held off until the back drains a group
//   reset: queue emptied, open group cleared, pad memory set to not-pad
module base64_stream_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  b64d_pkg::in_item_t       in_data,
    output logic                     empty,
    input  logic                     pop,
    output b64d_pkg::out_item_t      out_data
);

    // front to queue
    logic                    q_push;
    b64d_pkg::group_rec_t    q_rec;

    // queue to back
    b64d_pkg::group_rec_t    q_head;
    b64d_pkg::queue_status_t q_status;
    logic                    q_pop;

    // full is the queue's full flag: the front never stalls otherwise
    assign full = q_status.full;

    b64d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .q_full   (q_status.full),
        .q_push   (q_push),
        .q_rec    (q_rec)
    );

    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_rec   (q_rec),
        .rd       (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    b64d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (q_status.empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data)
    );

endmodule

[tb/sv/b64d_tb_pkg.sv]
// b64d_tb_pkg: decode tracker for the base64 stream decoder testbench
// predicts the bytes each accepted character releases and checks popped bytes
// depends on b64d_pkg
package b64d_tb_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    class b64_decode_tracker;

        logic [5:0]          held_sextets [3];
        logic [1:0]          held_count;
        bit                  last_was_pad;
        b64d_pkg::out_item_t expected_bytes [$];
        int                  mismatches;

        function new();
            held_sextets = '{default: '0};
            held_count   = '0;
            last_was_pad = 1'b0;
            mismatches   = 0;
        endfunction

        static function logic [5:0] sextet_value(logic [7:0] ch);
            if (ch >= "A" && ch <= "Z") return 6'(ch - "A");
            if (ch >= "a" && ch <= "z") return 6'(ch - "a" + 26);
            if (ch >= "0" && ch <= "9") return 6'(ch - "0" + 52);
            if (ch == "+") return 6'd62;
            if (ch == "/") return 6'd63;
            return 6'd0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // accepted character: update the open group, queue bytes when it closes
        function void take_char(b64d_pkg::in_item_t item);
            logic [5:0]          val;
            logic [5:0]          v [4];
            logic [7:0]          dec [3];
            bit                  is_pad;
            bit                  pad_prev;
            int                  n;
            b64d_pkg::out_item_t res;
            val          = sextet_value(item.char_in);
            is_pad       = (item.char_in == PAD_CHAR);
            pad_prev     = last_was_pad;
            last_was_pad = is_pad;
            if (held_count < 2'd3 && !item.final_char) begin
                held_sextets[held_count] = val;
                held_count++;
                return;
            end
            for (int k = 0; k < 4; k++)
                v[k] = (k < held_count) ? held_sextets[k] : 6'd0;
            v[held_count] = val;
            n = 0;
            dec[n] = {v[0], v[1][5:4]};
            n++;
            if (!pad_prev) begin
                dec[n] = {v[1][3:0], v[2][5:2]};
                n++;
            end
            if (!is_pad) begin
                dec[n] = {v[2][1:0], v[3]};
                n++;
            end
            for (int k = 0; k < n; k++) begin
                res.byte_out   = dec[k];
                res.group_last = (k == n - 1);
                res.stream_end = (k == n - 1) && item.final_char;
                expected_bytes.push_back(res);
            end
            held_sextets = '{default: '0};
            held_count   = '0;
        endfunction

        function void check_byte(b64d_pkg::out_item_t got);
            b64d_pkg::out_item_t want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected byte: expected none, actual %h/%b/%b",
                         $time, got.byte_out, got.group_last, got.stream_end);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.byte_out !== want.byte_out) begin
                mismatches++;
                $display("%0t: byte_out expected %h actual %h",
                         $time, want.byte_out, got.byte_out);
            end
            if (got.group_last !== want.group_last) begin
                mismatches++;
                $display("%0t: group_last expected %b actual %b",
                         $time, want.group_last, got.group_last);
            end
            if (got.stream_end !== want.stream_end) begin
                mismatches++;
                $display("%0t: stream_end expected %b actual %b",
                         $time, want.stream_end, got.stream_end);
            end
        endfunction

    endclass

endpackage

[tb/sv/tb_top.sv]
// tb_top: regression bench for base64_stream_decoder
// directed and random character streams against a decode tracker, random idling
// depends on b64d_pkg, b64d_tb_pkg and the decoder rtl
module tb_top;

    localparam int RANDOM_CHARS = 480;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;

    // how a well-formed random stream ends
    typedef enum int {
        TAIL_FULL,
        TAIL_TWO_PADS,
        TAIL_ONE_PAD,
        TAIL_SHORT
    } tail_kind_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    b64d_pkg::in_item_t  in_data;
    logic                empty;
    logic                pop;
    b64d_pkg::out_item_t out_data;

    b64d_tb_pkg::b64_decode_tracker tracker;

    int chars_sent;
    int rx_hold_req;
    bit tx_burst;
    bit rx_burst;

    base64_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // random character from the base64 alphabet
    function automatic logic [7:0] b64_random_char();
        int v;
        v = $urandom_range(0, 63);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    // one character transfer: optional idle gap, then hold push until full is low
    // inputs move on the falling edge, full is sampled on the rising edge
    task automatic send_char(input logic [7:0] ch, input bit fin);
        int                 gap;
        b64d_pkg::in_item_t item;
        gap             = tx_burst ? 0 : $urandom_range(0, 16);
        item.char_in    = ch;
        item.final_char = fin;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        push    <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (full);
        tracker.take_char(item);
        chars_sent++;
    endtask

    // a text string, final flag optionally on its last character
    task automatic send_text(input string s, input bit fin_last);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], fin_last && (k == s.len() - 1));
    endtask

    // sender stops offering and waits for every predicted byte to come out
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // well-formed encoded string: whole groups plus a random kind of ending
    task automatic send_stream();
        int         groups;
        int         n;
        tail_kind_t tail;
        groups = $urandom_range(0, 4);
        tail   = tail_kind_t'($urandom_range(0, 3));
        if (groups == 0 && tail == TAIL_FULL)
            groups = 1;
        for (int g = 0; g < groups; g++)
            for (int k = 0; k < 4; k++)
                send_char(b64_random_char(),
                          tail == TAIL_FULL && g == groups - 1 && k == 3);
        case (tail)
            TAIL_TWO_PADS:
            begin
                send_char(b64_random_char(), 1'b0);
                send_char(b64_random_char(), 1'b0);
                send_char(b64d_tb_pkg::PAD_CHAR, 1'b0);
                send_char(b64d_tb_pkg::PAD_CHAR, 1'b1);
            end
            TAIL_ONE_PAD:
            begin
                repeat (3)
                    send_char(b64_random_char(), 1'b0);
                send_char(b64d_tb_pkg::PAD_CHAR, 1'b1);
            end
            TAIL_SHORT:
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    send_char(b64_random_char(), k == n - 1);
            end
            default:
            begin
            end
        endcase
    endtask

    // noise: raw bytes, stray pads and final flags anywhere
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
            send_char(($urandom_range(0, 7) == 0) ? b64d_tb_pkg::PAD_CHAR
                                                  : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0);
    endtask

    // cycle watchdog ends a hung run
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("base64_stream_decoder regression: fail");
        $finish;
    end

    // result side: random pop gaps, bursts with no gaps, and one long hold
    // requested by the sender side; each popped byte goes to the tracker
    initial
    begin : result_side
        int gap;
        int hold;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
                repeat (hold)
                begin
                    @(negedge clk);
                    pop <= 1'b0;
                    @(posedge clk);
                end
            end
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 16);
            repeat (gap)
            begin
                @(negedge clk);
                pop <= 1'b0;
                @(posedge clk);
            end
            @(negedge clk);
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            tracker.check_byte(out_data);
        end
    end

    // stimulus and end of run
    initial
    begin : char_side
        int  directed_chars;
        bit  hold_done;
        bit  pause_done;
        int  burst_end;
        tracker     = new();
        chars_sent  = 0;
        rx_hold_req = 0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        in_data     = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: alphabet edges, full group without and with final flag
        send_text("AZaz", 1'b0);
        send_text("09+/", 1'b1);
        // zero byte and 0xff decode as zero; two pads end the group
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("==", 1'b0);
        // one-char final group right after a pad: pad memory drops byte two
        send_text("Q", 1'b1);
        // short final groups of two and three characters
        send_text("TW", 1'b1);
        send_text("TWF", 1'b1);
        // padded endings
        send_text("TQ==", 1'b1);
        send_text("TWE=", 1'b1);
        directed_chars = chars_sent;
        wait_drained();

        while (chars_sent < directed_chars + RANDOM_CHARS)
        begin
            if (!hold_done && chars_sent >= directed_chars + 150)
            begin
                // receiver holds off while the sender streams back to back,
                // so the group queue fills and full stalls the input
                rx_hold_req = HOLD_CYCLES;
                tx_burst    = 1'b1;
                burst_end   = chars_sent + 64;
                while (chars_sent < burst_end)
                    send_stream();
                hold_done = 1'b1;
            end
            if (!pause_done && chars_sent >= directed_chars + 320)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_stream();
        end

        wait_drained();
        repeat (16)
            @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("base64_stream_decoder regression: pass");
        else
            $display("base64_stream_decoder regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
tb/sv/b64d_tb_pkg.sv
tb/sv/tb_top.sv
